// ===== design/tbfr_pkg.sv =====
// Shared types, codes and defaults for the TDF bitstream field reader.
`timescale 1ns / 1ps

package tbfr_pkg;

  localparam int BUFFER_BYTES_DEF = 16;
  localparam int VALUE_W          = 32;
  localparam int TDF_GROUP_BITS   = 4;

  // Operation codes carried in the op field
  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_READ_FIXED = 3'd1,
    OP_READ_EXT   = 3'd2,
    OP_READ_TDF   = 3'd3,
    OP_ALIGN      = 3'd4,
    OP_CLEAR      = 3'd5
  } op_t;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Group decode modes of the shared group unit
  typedef enum logic [1:0] {
    GRP_FIXED = 2'd0,
    GRP_EXT   = 2'd1,
    GRP_TDF   = 2'd2
  } grp_mode_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic [5:0] field_width;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         status;
    logic [7:0]         bits_available;
  } out_item_t;

  // Sequencer to group unit
  typedef struct packed {
    logic      start;
    logic      shift;
    logic      bit_in;
    grp_mode_t mode;
    logic [5:0] width;
  } grp_ctl_t;

  // Group unit to sequencer
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
  } grp_sts_t;

endpackage

// ===== design/tbfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/tbfr_group_unit.sv =====
// Shared bit-serial group unit: collects bits into groups and folds them into the value.
`timescale 1ns / 1ps

module tbfr_group_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  tbfr_pkg::grp_ctl_t ctl,
  output tbfr_pkg::grp_sts_t sts
);

  logic [tbfr_pkg::VALUE_W-1:0] grp_r, grp_nxt;
  logic [tbfr_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic [tbfr_pkg::VALUE_W-1:0] step_r, step_nxt;
  logic [5:0]                   cnt_r, cnt_nxt;
  logic [5:0]                   len_r, len_nxt;
  tbfr_pkg::grp_mode_t          mode_r, mode_nxt;

  logic [5:0]                   width_eff;
  logic [tbfr_pkg::VALUE_W-1:0] grp_new;
  logic [5:0]                   cnt_new;
  logic                         last;
  logic [tbfr_pkg::VALUE_W-1:0] ext_addend;
  logic [tbfr_pkg::VALUE_W-1:0] fold_value;
  logic                         fold_done;

  // Clamp the field width into 1..32
  always_comb begin
    if (ctl.width == 6'd0) begin
      width_eff = 6'd1;
    end else if (ctl.width > 6'd32) begin
      width_eff = 6'd32;
    end else begin
      width_eff = ctl.width;
    end
  end

  assign grp_new    = {grp_r[tbfr_pkg::VALUE_W-2:0], ctl.bit_in};
  assign cnt_new    = cnt_r + 6'd1;
  assign last       = (cnt_new == len_r);
  assign ext_addend = (grp_new == '0) ? step_r : grp_new;

  always_comb begin
    case (mode_r)
      tbfr_pkg::GRP_FIXED: begin
        fold_value = grp_new;
        fold_done  = last;
      end
      tbfr_pkg::GRP_EXT: begin
        fold_value = acc_r + ext_addend;
        fold_done  = last && (grp_new != '0);
      end
      tbfr_pkg::GRP_TDF: begin
        fold_value = {acc_r[tbfr_pkg::VALUE_W-4:0], grp_new[2:0]};
        fold_done  = last && grp_new[3];
      end
      default: begin
        fold_value = grp_new;
        fold_done  = last;
      end
    endcase
  end

  always_comb begin
    grp_nxt  = grp_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    mode_nxt = mode_r;
    if (ctl.start) begin
      grp_nxt  = '0;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      mode_nxt = ctl.mode;
      step_nxt = {tbfr_pkg::VALUE_W{1'b1}} >> (6'd32 - width_eff);
      len_nxt  = (ctl.mode == tbfr_pkg::GRP_TDF) ? 6'(tbfr_pkg::TDF_GROUP_BITS) : width_eff;
    end else if (ctl.shift) begin
      if (last) begin
        grp_nxt = '0;
        cnt_nxt = '0;
        acc_nxt = fold_value;
      end else begin
        grp_nxt = grp_new;
        cnt_nxt = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mode_r <= tbfr_pkg::GRP_FIXED;
    end else begin
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
    grp_r  <= grp_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    len_r  <= len_nxt;
  end

  assign sts.done  = ctl.shift && fold_done;
  assign sts.value = fold_value;

endmodule

// ===== design/tdf_bitstream_field_reader_top.sv =====
// Top level of the TDF bitstream field reader: byte ring, bit cursor and sequencer.
// Push, align, clear and unused codes go from accept straight to the result state; reads
// shift one bit per cycle through the shared group unit, with one RAM read and load per
// byte entered (S_FETCH, S_LOAD), before the result state hands the result to out_valid.
// Throughput: one transaction at a time; in_stall is high from accept until the result moves
// to the output register, which may still hold an earlier result. Synchronous active-low reset
// clears pointers, counts and handshake state; the byte ring holds no reset value.
`timescale 1ns / 1ps

module tdf_bitstream_field_reader_top #(
  parameter int BUFFER_BYTES = tbfr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tbfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tbfr_pkg::out_item_t out_data
);

  localparam int AW  = $clog2(BUFFER_BYTES);      // byte index width
  localparam int PW  = AW + 3;                    // bit pointer width
  localparam int HW  = $clog2(BUFFER_BYTES + 1);  // bytes held width
  localparam int AVW = HW + 3;                    // unread bit count width

  localparam logic [AW-1:0] BYTE_LAST = AW'(BUFFER_BYTES - 1);
  localparam logic [PW-1:0] RING_LAST = PW'(BUFFER_BYTES * 8 - 1);
  localparam logic [HW-1:0] HELD_FULL = HW'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_BIT,
    S_DONE
  } state_t;

  // Architectural reader state
  state_t                       state_r, state_nxt;
  logic [PW-1:0]                rbp_r, rbp_nxt;
  logic [AW-1:0]                wptr_r, wptr_nxt;
  logic [HW-1:0]                held_r, held_nxt;
  // Working cursor of the read in flight
  logic [PW-1:0]                cur_pos_r, cur_pos_nxt;
  logic [AVW-1:0]               cur_avail_r, cur_avail_nxt;
  logic [7:0]                   byte_r, byte_nxt;
  // Pending result
  logic [tbfr_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [1:0]                   res_status_r, res_status_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tbfr_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                         in_accept;
  logic [AVW-1:0]               unread;
  logic [AVW+7:0]               unread_ext;
  logic [7:0]                   bits_sat;
  logic [AW-1:0]                rbyte_step;
  logic [AW-1:0]                wptr_step;
  logic [PW-1:0]                pos_step;
  logic [AVW-1:0]               avail_dec;
  logic [AVW-1:0]               commit_bits;
  logic                         cur_bit;
  tbfr_pkg::grp_mode_t          grp_mode;
  tbfr_pkg::grp_ctl_t           grp_ctl;
  tbfr_pkg::grp_sts_t           grp_sts;
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [7:0]                   ram_rd_data;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Unread bits: whole held bytes less the consumed head of a partly read byte
  assign unread     = {held_r, 3'b000} - AVW'(rbp_r[2:0]);
  assign unread_ext = {8'b0, unread};
  assign bits_sat   = (unread_ext > (AVW + 8)'(255)) ? 8'hFF : unread_ext[7:0];

  // Ring wraps; the depth need not be a power of two
  assign rbyte_step = (rbp_r[PW-1:3] == BYTE_LAST) ? '0 : rbp_r[PW-1:3] + 1'b1;
  assign wptr_step  = (wptr_r == BYTE_LAST) ? '0 : wptr_r + 1'b1;
  assign pos_step   = (cur_pos_r == RING_LAST) ? '0 : cur_pos_r + 1'b1;
  assign avail_dec  = cur_avail_r - 1'b1;
  assign commit_bits = avail_dec + AVW'(pos_step[2:0]);

  // MSB first within each byte
  assign cur_bit = byte_r[~cur_pos_r[2:0]];

  always_comb begin
    case (in_data.op)
      tbfr_pkg::OP_READ_EXT: grp_mode = tbfr_pkg::GRP_EXT;
      tbfr_pkg::OP_READ_TDF: grp_mode = tbfr_pkg::GRP_TDF;
      default:               grp_mode = tbfr_pkg::GRP_FIXED;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rbp_nxt        = rbp_r;
    wptr_nxt       = wptr_r;
    held_nxt       = held_r;
    cur_pos_nxt    = cur_pos_r;
    cur_avail_nxt  = cur_avail_r;
    byte_nxt       = byte_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;
    grp_ctl        = '0;
    grp_ctl.mode   = grp_mode;
    grp_ctl.width  = in_data.field_width;
    grp_ctl.bit_in = cur_bit;

    // Drop the output transaction once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_value_nxt  = '0;
          res_status_nxt = tbfr_pkg::ST_OK;
          state_nxt      = S_DONE;
          case (in_data.op)
            tbfr_pkg::OP_PUSH: begin
              if (held_r >= HELD_FULL) begin
                res_status_nxt = tbfr_pkg::ST_FULL;
              end else begin
                ram_wr_en = 1'b1;
                wptr_nxt  = wptr_step;
                held_nxt  = held_r + 1'b1;
              end
            end
            tbfr_pkg::OP_READ_FIXED, tbfr_pkg::OP_READ_EXT, tbfr_pkg::OP_READ_TDF: begin
              grp_ctl.start = 1'b1;
              cur_pos_nxt   = rbp_r;
              cur_avail_nxt = unread;
              state_nxt     = S_FETCH;
            end
            tbfr_pkg::OP_ALIGN: begin
              // Drop the rest of a partly read byte
              if (rbp_r[2:0] != 3'b000) begin
                rbp_nxt  = {rbyte_step, 3'b000};
                held_nxt = held_r - 1'b1;
              end
            end
            tbfr_pkg::OP_CLEAR: begin
              rbp_nxt  = '0;
              wptr_nxt = '0;
              held_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        ram_rd_en = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        byte_nxt  = ram_rd_data;
        state_nxt = S_BIT;
      end
      S_BIT: begin
        if (cur_avail_r == '0) begin
          // Out of data: leave the committed pointers untouched
          res_value_nxt  = '0;
          res_status_nxt = tbfr_pkg::ST_NO_DATA;
          state_nxt      = S_DONE;
        end else begin
          grp_ctl.shift = 1'b1;
          cur_pos_nxt   = pos_step;
          cur_avail_nxt = avail_dec;
          if (grp_sts.done) begin
            res_value_nxt = grp_sts.value;
            rbp_nxt       = pos_step;
            held_nxt      = commit_bits[AVW-1:3];
            state_nxt     = S_DONE;
          end else if (pos_step[2:0] == 3'b000) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.value          = res_value_r;
          out_data_nxt.status         = res_status_r;
          out_data_nxt.bits_available = bits_sat;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rbp_r       <= '0;
      wptr_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rbp_r       <= rbp_nxt;
      wptr_r      <= wptr_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_pos_r    <= cur_pos_nxt;
    cur_avail_r  <= cur_avail_nxt;
    byte_r       <= byte_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  tbfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wptr_r),
    .wr_data (in_data.data_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (cur_pos_r[PW-1:3]),
    .rd_data (ram_rd_data)
  );

  tbfr_group_unit u_group (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (grp_ctl),
    .sts   (grp_sts)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_FULL)
    else $error("bytes held exceeds ring depth");

  a_partial_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
    (rbp_r[2:0] != 3'b000) |-> (held_r != '0))
    else $error("partly read byte with no bytes held");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("output transaction raised outside result state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != S_IDLE))
    else $error("accepted transaction left the sequencer idle");
`endif

endmodule

// ===== bench/tb_tdf_bitstream_field_reader_top.sv =====
// Self-checking testbench for the TDF bitstream field reader: random and directed traffic.
`timescale 1ns / 1ps

module tb_tdf_bitstream_field_reader_top;

  localparam int          BUF        = tbfr_pkg::BUFFER_BYTES_DEF;
  localparam int unsigned RING_BITS  = BUF * 8;
  localparam int          CYCLE_CAP  = 2_000_000;
  localparam int          TAIL_WAIT  = 200;
  localparam int          HOLD_AT    = 300;   // results seen before the long receiver hold-off
  localparam int          HOLD_LEN   = 400;
  // op codes the block leaves unused
  localparam logic [2:0]  OP_SPARE6  = 3'd6;
  localparam logic [2:0]  OP_SPARE7  = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  tbfr_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tbfr_pkg::out_item_t out_data;

  tdf_bitstream_field_reader_top #(.BUFFER_BYTES(BUF)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the reader state
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_ring [BUF];
  int unsigned shadow_rd_bit = 0;
  int unsigned shadow_wr_byte = 0;
  int unsigned shadow_held = 0;

  tbfr_pkg::in_item_t  request_q[$];
  tbfr_pkg::out_item_t expected_reply_q[$];

  int errors = 0;
  int reported = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic int unsigned shadow_unread();
    return shadow_held * 8 - (shadow_rd_bit & 7);
  endfunction

  // Pull n bits MSB first from a trial cursor; leave the cursor alone on shortage.
  function automatic bit grab_bits(inout int unsigned pos, inout int unsigned avail,
                                   input int unsigned n, output logic [31:0] v);
    logic [31:0] acc;
    logic [7:0]  b;
    int unsigned i;
    acc = '0;
    v = '0;
    if (avail < n) return 1'b0;
    for (i = 0; i < n; i++) begin
      b = shadow_ring[(pos >> 3) % BUF];
      acc = {acc[30:0], b[7 - (pos & 7)]};
      pos = (pos + 1) % RING_BITS;
      avail--;
    end
    v = acc;
    return 1'b1;
  endfunction

  // Work out the reply to one request and advance the shadow state.
  function automatic tbfr_pkg::out_item_t predict_reader(tbfr_pkg::in_item_t req);
    tbfr_pkg::out_item_t r;
    int unsigned n, pos, avail, unread;
    logic [31:0] acc, grp, step_v;
    bit          ok, done;
    r = '0;
    n = 32'(req.field_width);
    if (n == 0) n = 1;
    if (n > 32) n = 32;
    pos = shadow_rd_bit % RING_BITS;
    avail = shadow_unread();
    acc = '0;
    ok = 1'b1;
    done = 1'b0;
    case (req.op)
      tbfr_pkg::OP_PUSH: begin
        if (shadow_held >= BUF) begin
          r.status = tbfr_pkg::ST_FULL;
        end else begin
          shadow_ring[shadow_wr_byte % BUF] = req.data_byte;
          shadow_wr_byte = (shadow_wr_byte + 1) % BUF;
          shadow_held++;
        end
      end
      tbfr_pkg::OP_READ_FIXED: begin
        ok = grab_bits(pos, avail, n, grp);
        acc = grp;
      end
      tbfr_pkg::OP_READ_EXT: begin
        // all-zero groups add 2^n-1 each, wrapping at width 32
        step_v = (n == 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        while (!done) begin
          ok = grab_bits(pos, avail, n, grp);
          if (!ok) begin
            done = 1'b1;
          end else if (grp != 0) begin
            acc = acc + grp;
            done = 1'b1;
          end else begin
            acc = acc + step_v;
          end
        end
      end
      tbfr_pkg::OP_READ_TDF: begin
        while (!done) begin
          ok = grab_bits(pos, avail, tbfr_pkg::TDF_GROUP_BITS, grp);
          if (!ok) begin
            done = 1'b1;
          end else begin
            acc = (acc << 3) + {29'd0, grp[2:0]};
            if (grp[3]) done = 1'b1;
          end
        end
      end
      tbfr_pkg::OP_ALIGN: begin
        if ((pos & 7) != 0) begin
          avail = avail - (8 - (pos & 7));
          pos = ((pos | 7) + 1) % RING_BITS;
        end
      end
      tbfr_pkg::OP_CLEAR: begin
        shadow_rd_bit = 0;
        shadow_wr_byte = 0;
        shadow_held = 0;
      end
      default: ;
    endcase
    if (req.op >= tbfr_pkg::OP_READ_FIXED && req.op <= tbfr_pkg::OP_ALIGN) begin
      if (ok) begin
        shadow_rd_bit = pos;
        shadow_held = (avail + (pos & 7)) >> 3;
        r.value = acc;
      end else begin
        r.status = tbfr_pkg::ST_NO_DATA;
        r.value = '0;
      end
    end
    unread = shadow_unread();
    r.bits_available = (unread > 255) ? 8'd255 : unread[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic tbfr_pkg::in_item_t pack_req(logic [2:0] op, logic [7:0] d,
                                                  logic [5:0] w);
    tbfr_pkg::in_item_t it;
    it.op = op;
    it.data_byte = d;
    it.field_width = w;
    return it;
  endfunction

  // Bias toward zero bytes so extended reads see zero groups.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r == 3) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [5:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 6'($urandom_range(1, 8));
    if (r < 17) return 6'($urandom_range(9, 32));
    if (r < 19) return 6'd0;
    return 6'($urandom_range(33, 63));
  endfunction

  function automatic tbfr_pkg::in_item_t pick_read();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 35)      op = tbfr_pkg::OP_READ_FIXED;
    else if (r < 60) op = tbfr_pkg::OP_READ_EXT;
    else if (r < 85) op = tbfr_pkg::OP_READ_TDF;
    else if (r < 95) op = tbfr_pkg::OP_ALIGN;
    else             op = tbfr_pkg::OP_CLEAR;
    return pack_req(op, 8'($urandom_range(0, 255)), pick_width());
  endfunction

  // Mostly records of a few pushed bytes followed by reads; the rest raw noise.
  task automatic queue_random(input int count);
    int made, k, j;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(1, 6);
        for (j = 0; j < k; j++) begin
          request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, pick_byte(),
                                       6'($urandom_range(0, 63))));
          made++;
        end
        k = $urandom_range(1, 3);
        for (j = 0; j < k; j++) begin
          request_q.push_back(pick_read());
          made++;
        end
      end else begin
        request_q.push_back(pack_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                     6'($urandom_range(0, 63))));
        made++;
      end
    end
  endtask

  // Block until every queued request is accepted and every reply has arrived.
  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || expected_reply_q.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps; hold the payload while stalled
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reply_q.push_back(predict_reader(in_data));
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 24);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall density changes in phases; one long hold-off to back up the block
  // ---------------------------------------------------------------------------
  int  stall_pct = 0;
  int  phase_left = 0;
  int  holdoff_left = 0;
  bit  holdoff_used = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!holdoff_used && results_seen >= HOLD_AT) begin
      holdoff_used = 1'b1;
      holdoff_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
        phase_left = $urandom_range(16, 128);
      end else begin
        phase_left--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted reply with the oldest prediction
  // ---------------------------------------------------------------------------
  tbfr_pkg::out_item_t oldest;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_reply_q.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected reply: value=%h status=%0d bits=%0d",
                   out_data.value, out_data.status, out_data.bits_available);
        reported++;
      end else begin
        oldest = expected_reply_q.pop_front();
        if (out_data.value !== oldest.value || out_data.status !== oldest.status ||
            out_data.bits_available !== oldest.bits_available) begin
          errors++;
          if (reported < 10)
            $display({"mismatch: exp value=%h status=%0d bits=%0d, ",
                      "got value=%h status=%0d bits=%0d"},
                     oldest.value, oldest.status, oldest.bits_available,
                     out_data.value, out_data.status, out_data.bits_available);
          reported++;
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_tdf_bitstream_field_reader_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // read from an empty ring, unused codes
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_FIXED, 8'h00, 6'd1));
    request_q.push_back(pack_req(OP_SPARE6, 8'hFF, 6'd63));
    request_q.push_back(pack_req(OP_SPARE7, 8'h00, 6'd0));
    // width zero acts as one, width above 32 acts as 32 and runs short
    request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'hA5, 6'd63));
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_FIXED, 8'hFF, 6'd0));
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_FIXED, 8'h00, 6'd63));
    request_q.push_back(pack_req(tbfr_pkg::OP_ALIGN, 8'h00, 6'd1));
    // fill the ring: zero word, ones word, then TDF groups
    for (i = 0; i < 4; i++) request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'h00, 6'd1));
    for (i = 0; i < 4; i++) request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'hFF, 6'd1));
    for (i = 0; i < 8; i++)
      request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'h12 + 8'(i) * 8'h22, 6'd1));
    // push into a full ring
    request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'h5A, 6'd1));
    // width 32 extended read wraps on the zero group
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_EXT, 8'h00, 6'd32));
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_TDF, 8'h00, 6'd1));
    request_q.push_back(pack_req(tbfr_pkg::OP_CLEAR, 8'h00, 6'd1));
    // TDF integer that runs out of data partway
    request_q.push_back(pack_req(tbfr_pkg::OP_PUSH, 8'h00, 6'd1));
    request_q.push_back(pack_req(tbfr_pkg::OP_READ_TDF, 8'h00, 6'd1));
    wait_drained();

    queue_random(700);
    wait_drained();   // sender pause with everything delivered
    queue_random(800);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk);
    errors += expected_reply_q.size();
    if (errors == 0)
      $display("tb_tdf_bitstream_field_reader_top: clean");
    else
      $display("tb_tdf_bitstream_field_reader_top: errors");
    $finish;
  end

endmodule
